// File: design/lst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lst_pkg;

  localparam int LEAVES_DEF = 1024;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_ASSIGN = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_ARGMAX = 2'd3
  } cmd_t;

  typedef enum logic [0:0] {
    OP_ADD = 1'b0,   // saturating a + b
    OP_MAX = 1'b1    // signed max, left wins a tie
  } alu_op_t;

  // one tree node: subtree max without own tag, pending add, assign flag
  typedef struct packed {
    logic signed [31:0] val;
    logic signed [31:0] pa;
    logic               ap;
  } node_t;

endpackage

`default_nettype wire

// File: design/lst_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module lst_alu (
  input  lst_pkg::alu_op_t   op,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [31:0] res,
  output logic               a_ge_b
);
  import lst_pkg::*;

  logic signed [32:0] sum;

  assign sum    = {a[31], a} + {b[31], b};
  assign a_ge_b = (a >= b);

  always_comb begin
    unique case (op)
      OP_ADD: begin
        if (sum[32] != sum[31]) begin
          res = sum[32] ? VAL_MIN : VAL_MAX;
        end else begin
          res = sum[31:0];
        end
      end
      OP_MAX: begin
        res = a_ge_b ? a : b;
      end
      default: begin
        res = a;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/lst_node_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lst_node_ram #(
  parameter int AW = 11
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  lst_pkg::node_t wr_data,
  input  logic [AW-1:0] rd_addr,
  output lst_pkg::node_t rd_data
);
  import lst_pkg::*;

  node_t mem [0:(1 << AW) - 1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: design/lazy_segment_tree_range_max_core.sv
// Walk: add/assign/query walk the tree depth first, visiting roughly 4*log2(LEAVES) nodes,
//   paced by the node RAM (one read port, one write port) and the shared ALU.
// Argmax: per tree level, reads the node, pushes its tags to both children, then picks the larger child.
// Throughput: one command at a time; a waiting result does not block the next command,
//   but a second result holds in S_RES until the output register is free.
// Reset: synchronous, active-low rst_n; then a clearing pass writes every node, 1 to 2*P-1
//   (P = LEAVES rounded up to a power of two), before in_tready rises.
`timescale 1ns / 1ps
`default_nettype none

module lazy_segment_tree_range_max_core #(
  parameter int LEAVES = lst_pkg::LEAVES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // cmd[1:0], range_left[12:2], range_right[23:13], value[55:24]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // max_value[31:0], max_index[41:32], zero pad
);
  import lst_pkg::*;

  localparam int PW = $clog2(LEAVES);          // tree levels below the root
  localparam int NW = PW + 1;                  // node index width
  localparam int CW = PW + 1;                  // element coordinate width, holds P
  localparam int BW = (PW + 1 > 11) ? PW + 1 : 11;
  localparam logic [CW-1:0] P_C  = CW'(1) << PW;
  localparam logic [CW-1:0] LV_C = CW'(LEAVES);
  localparam logic [BW-1:0] LV_B = BW'(LEAVES);

  typedef enum logic [19:0] {
    S_CLEAR  = 20'd1 << 0,
    S_IDLE   = 20'd1 << 1,
    S_VISIT  = 20'd1 << 2,
    S_COV_RD = 20'd1 << 3,
    S_COV    = 20'd1 << 4,
    S_QMAX   = 20'd1 << 5,
    S_PD_RD  = 20'd1 << 6,
    S_PD_I   = 20'd1 << 7,
    S_PD_A   = 20'd1 << 8,
    S_PD_B   = 20'd1 << 9,
    S_PD_W   = 20'd1 << 10,
    S_AM_GA  = 20'd1 << 11,
    S_AM_GB  = 20'd1 << 12,
    S_AM_SEL = 20'd1 << 13,
    S_UP     = 20'd1 << 14,
    S_RC_RA  = 20'd1 << 15,
    S_RC_A   = 20'd1 << 16,
    S_RC_B   = 20'd1 << 17,
    S_RC_M   = 20'd1 << 18,
    S_RES    = 20'd1 << 19
  } state_t;

  state_t state_r, state_nxt;

  // command beat
  cmd_t               cmd_r, cmd_nxt;
  logic [CW-1:0]      l_r, l_nxt;
  logic [CW-1:0]      r_r, r_nxt;
  logic signed [31:0] x_r, x_nxt;

  // walk position: node index, its first element and its span
  logic [NW-1:0]      i_r, i_nxt;
  logic [CW-1:0]      tl_r, tl_nxt;
  logic [CW-1:0]      size_r, size_nxt;

  // working registers
  logic signed [31:0] acc_r, acc_nxt;
  logic signed [31:0] vi_r, vi_nxt;     // parent value after its add tag is folded in
  logic signed [31:0] d_r, d_nxt;       // parent add tag being pushed
  logic               api_r, api_nxt;   // parent assign flag being pushed
  node_t              wa_r, wa_nxt;
  node_t              wb_r, wb_nxt;
  logic signed [31:0] ga_r, ga_nxt;
  logic signed [31:0] gb_r, gb_nxt;
  logic signed [31:0] res_val_r, res_val_nxt;
  logic [9:0]         res_idx_r, res_idx_nxt;

  logic               out_tvalid_r;
  logic [47:0]        out_data_r;

  // RAM and ALU hookup
  logic               wr_en;
  logic [NW-1:0]      wr_addr;
  node_t              wr_data;
  logic [NW-1:0]      rd_addr;
  node_t              rd_data;
  alu_op_t            alu_op;
  logic signed [31:0] alu_a, alu_b, alu_res;
  logic               alu_ge;

  // input unpack, swap and clamp
  logic               in_fire;
  logic [BW-1:0]      lft_b, rgt_b, lo_b, hi_b, lo_c, hi_c;
  logic [CW-1:0]      lo_w, hi_w;

  logic [NW-1:0]      a_addr, b_addr, sel_node;
  logic [CW-1:0]      tl_end;
  logic               disjoint, covered;
  logic [PW+9:0]      leaf_ext;
  node_t              cnew;
  logic               out_load;

  assign in_fire = in_tvalid && in_tready;
  assign lft_b   = BW'(in_tdata[12:2]);
  assign rgt_b   = BW'(in_tdata[23:13]);
  assign lo_b    = (lft_b > rgt_b) ? rgt_b : lft_b;
  assign hi_b    = (lft_b > rgt_b) ? lft_b : rgt_b;
  assign lo_c    = (lo_b > LV_B) ? LV_B : lo_b;
  assign hi_c    = (hi_b > LV_B) ? LV_B : hi_b;
  assign lo_w    = CW'(lo_c);
  assign hi_w    = CW'(hi_c);

  assign a_addr   = {i_r[NW-2:0], 1'b0};
  assign b_addr   = {i_r[NW-2:0], 1'b1};
  assign sel_node = {i_r[NW-2:0], ~alu_ge};
  assign leaf_ext = {10'd0, sel_node[PW-1:0]};
  assign tl_end   = tl_r + size_r;
  assign disjoint = (r_r <= tl_r) || (tl_end <= l_r);
  assign covered  = (l_r <= tl_r) && (tl_end <= r_r);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_load   = (state_r == S_RES) && (!out_tvalid_r || out_tready);

  lst_node_ram #(
    .AW (NW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lst_alu u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .res    (alu_res),
    .a_ge_b (alu_ge)
  );

  // pushed child: an assign overwrites it, else its add tag absorbs the parent's
  always_comb begin
    if (api_r) begin
      cnew.val = vi_r;
      cnew.pa  = '0;
      cnew.ap  = 1'b1;
    end else begin
      cnew.val = rd_data.val;
      cnew.pa  = alu_res;
      cnew.ap  = rd_data.ap;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    l_nxt       = l_r;
    r_nxt       = r_r;
    x_nxt       = x_r;
    i_nxt       = i_r;
    tl_nxt      = tl_r;
    size_nxt    = size_r;
    acc_nxt     = acc_r;
    vi_nxt      = vi_r;
    d_nxt       = d_r;
    api_nxt     = api_r;
    wa_nxt      = wa_r;
    wb_nxt      = wb_r;
    ga_nxt      = ga_r;
    gb_nxt      = gb_r;
    res_val_nxt = res_val_r;
    res_idx_nxt = res_idx_r;
    wr_en       = 1'b0;
    wr_addr     = i_r;
    wr_data     = '0;
    rd_addr     = i_r;
    alu_op      = OP_ADD;
    alu_a       = '0;
    alu_b       = '0;

    unique case (state_r)
      S_CLEAR: begin
        // nodes in index order, level by level; padding-only subtrees get the floor
        wr_en       = 1'b1;
        wr_data.val = (tl_r < LV_C) ? 32'sd0 : VAL_MIN;
        if (i_r == {NW{1'b1}}) begin
          i_nxt     = NW'(1);
          tl_nxt    = '0;
          size_nxt  = P_C;
          state_nxt = S_IDLE;
        end else begin
          i_nxt = i_r + NW'(1);
          if (tl_end == P_C) begin
            tl_nxt   = '0;
            size_nxt = size_r >> 1;
          end else begin
            tl_nxt = tl_end;
          end
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt  = cmd_t'(in_tdata[1:0]);
          l_nxt    = lo_w;
          r_nxt    = hi_w;
          x_nxt    = in_tdata[55:24];
          i_nxt    = NW'(1);
          tl_nxt   = '0;
          size_nxt = P_C;
          acc_nxt  = VAL_MIN;
          if (cmd_t'(in_tdata[1:0]) == CMD_ARGMAX) begin
            state_nxt = S_PD_RD;
          end else if (lo_w == hi_w) begin
            if (cmd_t'(in_tdata[1:0]) == CMD_QUERY) begin
              res_val_nxt = VAL_MIN;
              res_idx_nxt = '0;
              state_nxt   = S_RES;
            end
          end else begin
            state_nxt = S_VISIT;
          end
        end
      end
      S_VISIT: begin
        priority if (disjoint) begin
          state_nxt = S_UP;
        end else if (covered) begin
          state_nxt = S_COV_RD;
        end else begin
          state_nxt = S_PD_RD;
        end
      end
      S_COV_RD: begin
        state_nxt = S_COV;
      end
      S_COV: begin
        unique case (cmd_r)
          CMD_ADD: begin
            alu_a       = rd_data.pa;
            alu_b       = x_r;
            wr_en       = 1'b1;
            wr_data.val = rd_data.val;
            wr_data.pa  = alu_res;
            wr_data.ap  = rd_data.ap;
            state_nxt   = S_UP;
          end
          CMD_ASSIGN: begin
            wr_en       = 1'b1;
            wr_data.val = x_r;
            wr_data.ap  = 1'b1;
            state_nxt   = S_UP;
          end
          default: begin
            alu_a     = rd_data.val;
            alu_b     = rd_data.pa;
            ga_nxt    = alu_res;
            state_nxt = S_QMAX;
          end
        endcase
      end
      S_QMAX: begin
        alu_op    = OP_MAX;
        alu_a     = acc_r;
        alu_b     = ga_r;
        acc_nxt   = alu_res;
        state_nxt = S_UP;
      end
      S_PD_RD: begin
        state_nxt = S_PD_I;
      end
      S_PD_I: begin
        alu_a     = rd_data.val;
        alu_b     = rd_data.pa;
        vi_nxt    = alu_res;
        d_nxt     = rd_data.pa;
        api_nxt   = rd_data.ap;
        rd_addr   = a_addr;
        state_nxt = S_PD_A;
      end
      S_PD_A: begin
        alu_a     = rd_data.pa;
        alu_b     = d_r;
        wr_en     = 1'b1;
        wr_addr   = a_addr;
        wr_data   = cnew;
        wa_nxt    = cnew;
        rd_addr   = b_addr;
        state_nxt = S_PD_B;
      end
      S_PD_B: begin
        alu_a     = rd_data.pa;
        alu_b     = d_r;
        wr_en     = 1'b1;
        wr_addr   = b_addr;
        wr_data   = cnew;
        wb_nxt    = cnew;
        state_nxt = S_PD_W;
      end
      S_PD_W: begin
        wr_en       = 1'b1;
        wr_data.val = vi_r;
        if (cmd_r == CMD_ARGMAX) begin
          state_nxt = S_AM_GA;
        end else begin
          i_nxt     = a_addr;
          size_nxt  = size_r >> 1;
          state_nxt = S_VISIT;
        end
      end
      S_AM_GA: begin
        alu_a     = wa_r.val;
        alu_b     = wa_r.pa;
        ga_nxt    = alu_res;
        state_nxt = S_AM_GB;
      end
      S_AM_GB: begin
        alu_a     = wb_r.val;
        alu_b     = wb_r.pa;
        gb_nxt    = alu_res;
        state_nxt = S_AM_SEL;
      end
      S_AM_SEL: begin
        alu_op = OP_MAX;
        alu_a  = ga_r;
        alu_b  = gb_r;
        i_nxt  = sel_node;
        if (i_r[PW-1]) begin
          res_val_nxt = alu_res;
          res_idx_nxt = leaf_ext[9:0];
          state_nxt   = S_RES;
        end else begin
          state_nxt = S_PD_RD;
        end
      end
      S_UP: begin
        priority if (i_r == NW'(1)) begin
          if (cmd_r == CMD_QUERY) begin
            res_val_nxt = acc_r;
            res_idx_nxt = '0;
            state_nxt   = S_RES;
          end else begin
            state_nxt = S_IDLE;
          end
        end else if (!i_r[0]) begin
          i_nxt     = i_r + NW'(1);
          tl_nxt    = tl_end;
          state_nxt = S_VISIT;
        end else begin
          i_nxt     = i_r >> 1;
          tl_nxt    = tl_r - size_r;
          size_nxt  = size_r << 1;
          state_nxt = (cmd_r == CMD_QUERY) ? S_UP : S_RC_RA;
        end
      end
      S_RC_RA: begin
        rd_addr   = a_addr;
        state_nxt = S_RC_A;
      end
      S_RC_A: begin
        alu_a     = rd_data.val;
        alu_b     = rd_data.pa;
        ga_nxt    = alu_res;
        rd_addr   = b_addr;
        state_nxt = S_RC_B;
      end
      S_RC_B: begin
        alu_a     = rd_data.val;
        alu_b     = rd_data.pa;
        gb_nxt    = alu_res;
        state_nxt = S_RC_M;
      end
      S_RC_M: begin
        // parent was pushed on the way down, so its tags are clear
        alu_op      = OP_MAX;
        alu_a       = ga_r;
        alu_b       = gb_r;
        wr_en       = 1'b1;
        wr_data.val = alu_res;
        state_nxt   = S_UP;
      end
      S_RES: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      i_r          <= NW'(1);
      tl_r         <= '0;
      size_r       <= P_C;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      tl_r    <= tl_nxt;
      size_r  <= size_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    l_r       <= l_nxt;
    r_r       <= r_nxt;
    x_r       <= x_nxt;
    acc_r     <= acc_nxt;
    vi_r      <= vi_nxt;
    d_r       <= d_nxt;
    api_r     <= api_nxt;
    wa_r      <= wa_nxt;
    wb_r      <= wb_nxt;
    ga_r      <= ga_nxt;
    gb_r      <= gb_nxt;
    res_val_r <= res_val_nxt;
    res_idx_r <= res_idx_nxt;
    if (out_load) begin
      out_data_r <= {6'd0, res_idx_r, res_val_r};
    end
  end

`ifndef SYNTHESIS
  a_size_onehot : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(size_r))
    else $error("node span lost its power-of-two form");

  a_span_in_tree : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_CLEAR) |-> (tl_end <= P_C))
    else $error("walk position left the tree");

  a_no_node_zero : assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (wr_addr != '0))
    else $error("write to unused node slot");

  a_clear_blocks : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_tready)
    else $error("input taken during clearing pass");

  a_res_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RES && out_tvalid_r && !out_tready) |=> (state_r == S_RES))
    else $error("result dropped while output busy");
`endif

endmodule

`default_nettype wire

// File: sim/lst_scoreboard.sv
`timescale 1ns / 1ps

// Watches both streams, keeps a shadow lazy tree, compares every result beat.
module lst_scoreboard #(
  parameter int LEAVES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [55:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  output int          fail_count,
  output int          pending
);
  import lst_pkg::*;

  localparam int P = (LEAVES <= 1) ? 1 : (1 << $clog2(LEAVES));

  typedef struct packed {
    logic signed [31:0] mx;
    logic [9:0]         idx;
  } max_result_t;

  logic signed [31:0] tree_val [0:2*P-1];
  logic signed [31:0] tree_add [0:2*P-1];
  bit                 tree_asg [0:2*P-1];
  max_result_t        max_results_q[$];

  int wi [0:127];
  int wl [0:127];
  int wr [0:127];
  int wp [0:127];

  function automatic logic signed [31:0] sat_sum(logic signed [31:0] a, logic signed [31:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > longint'(VAL_MAX)) return VAL_MAX;
    if (s < longint'(VAL_MIN)) return VAL_MIN;
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] smax(logic signed [31:0] a, logic signed [31:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [31:0] node_eff(int i);
    return sat_sum(tree_val[i], tree_add[i]);
  endfunction

  task automatic clear_tree();
    for (int i = 0; i < 2*P; i++) begin
      tree_add[i] = 0;
      tree_asg[i] = 0;
      tree_val[i] = VAL_MIN;
    end
    for (int i = 0; i < P; i++) tree_val[P+i] = (i < LEAVES) ? 32'sd0 : VAL_MIN;
    for (int i = P - 1; i > 0; i--) tree_val[i] = smax(tree_val[2*i], tree_val[2*i+1]);
  endtask

  task automatic push_tags(int i);
    logic signed [31:0] d;
    if (i >= P) return;
    d = tree_add[i];
    if (d != 0) begin
      tree_add[2*i]   = sat_sum(tree_add[2*i], d);
      tree_add[2*i+1] = sat_sum(tree_add[2*i+1], d);
      tree_val[i]     = sat_sum(tree_val[i], d);
      tree_add[i]     = 0;
    end
    if (tree_asg[i]) begin
      for (int c = 2*i; c <= 2*i+1; c++) begin
        tree_val[c] = tree_val[i];
        tree_add[c] = 0;
        tree_asg[c] = 1;
      end
      tree_asg[i] = 0;
    end
  endtask

  // explicit stack walk; phase 1 rebuilds a node after its children
  task automatic walk(int l, int r, logic signed [31:0] x, int mode,
                      output logic signed [31:0] best);
    int sp, i, tl, tr, ph, tm;
    sp = 1;
    wi[0] = 1; wl[0] = 0; wr[0] = P; wp[0] = 0;
    best = VAL_MIN;
    while (sp > 0) begin
      sp--;
      i = wi[sp]; tl = wl[sp]; tr = wr[sp]; ph = wp[sp];
      if (ph == 1) begin
        tree_val[i] = smax(node_eff(2*i), node_eff(2*i+1));
      end else if (!(r <= tl || tr <= l)) begin
        if (l <= tl && tr <= r) begin
          if (mode == CMD_ADD) tree_add[i] = sat_sum(tree_add[i], x);
          else if (mode == CMD_ASSIGN) begin
            tree_add[i] = 0;
            tree_val[i] = x;
            tree_asg[i] = 1;
          end else best = smax(best, node_eff(i));
        end else begin
          push_tags(i);
          tm = tl + (tr - tl) / 2;
          if (mode != CMD_QUERY) begin
            wi[sp] = i; wl[sp] = tl; wr[sp] = tr; wp[sp] = 1; sp++;
          end
          wi[sp] = 2*i+1; wl[sp] = tm; wr[sp] = tr; wp[sp] = 0; sp++;
          wi[sp] = 2*i;   wl[sp] = tl; wr[sp] = tm; wp[sp] = 0; sp++;
        end
      end
    end
  endtask

  task automatic predict_beat(logic [55:0] d);
    cmd_t               c;
    int                 l, r, t, i;
    logic signed [31:0] x, m;
    max_result_t        res;
    c = cmd_t'(d[1:0]);
    l = d[12:2];
    r = d[23:13];
    x = d[55:24];
    if (l > r) begin t = l; l = r; r = t; end
    if (l > LEAVES) l = LEAVES;
    if (r > LEAVES) r = LEAVES;
    case (c)
      CMD_ADD, CMD_ASSIGN: begin
        if (l < r) walk(l, r, x, c, m);
      end
      CMD_QUERY: begin
        m = VAL_MIN;
        if (l < r) walk(l, r, x, c, m);
        res.mx = m; res.idx = '0;
        max_results_q = {max_results_q, res};
      end
      default: begin
        i = 1;
        while (i < P) begin
          push_tags(i);
          i = (node_eff(2*i) >= node_eff(2*i+1)) ? 2*i : 2*i + 1;
        end
        res.mx = node_eff(i);
        res.idx = 10'(i - P);
        max_results_q = {max_results_q, res};
      end
    endcase
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    max_result_t e;
    if (!rst_n) begin
      clear_tree();
      max_results_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (max_results_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result beat %h", out_tdata);
        end else begin
          e = max_results_q.pop_front();
          if (out_tdata[31:0] !== e.mx || out_tdata[41:32] !== e.idx) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp max %0d idx %0d, got max %0d idx %0d",
                       e.mx, e.idx, $signed(out_tdata[31:0]), out_tdata[41:32]);
          end
        end
      end
      if (in_tvalid && in_tready) predict_beat(in_tdata);
    end
    pending = max_results_q.size();
  end

endmodule

// File: sim/tb_lazy_segment_tree_range_max_core.sv
`timescale 1ns / 1ps

module tb_lazy_segment_tree_range_max_core;
  import lst_pkg::*;

  localparam int LEAVES   = 1024;
  localparam int N_RANDOM = 1650;
  localparam int IDLE_CAP = 50000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [47:0] out_tdata;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  int          stall_tick = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  lazy_segment_tree_range_max_core #(.LEAVES(LEAVES)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  lst_scoreboard #(.LEAVES(LEAVES)) u_sb (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  // receiver: phases of always-ready, random stalls and a periodic stall
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    case ((stall_tick >> 9) % 3)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(9) < 6);
      default: out_tready <= ((stall_tick % 7) > 2);
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_CAP) begin
      $display("FAILURE");
      $finish;
    end
  end

  int burst_left = 0;

  // one beat; afterwards maybe a gap so bursts alternate with idle stretches
  task automatic send_beat(cmd_t c, int l, int r, logic signed [31:0] v);
    in_tdata  <= {v, 11'(r), 11'(l), c};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(12);
      if ($urandom_range(3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(5))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return $signed(32'($urandom_range(200))) - 100;
      3:       return $signed({$urandom_range(1) ? 2'b11 : 2'b00, 30'($urandom)});
      default: return $signed(32'($urandom));
    endcase
  endfunction

  function automatic int pick_bound();
    if ($urandom_range(9) == 0) return $urandom_range(2047);
    if ($urandom_range(3) == 0) return ($urandom_range(1) ? 0 : LEAVES);
    return $urandom_range(LEAVES);
  endfunction

  initial begin
    int l, r;
    cmd_t c;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    send_beat(CMD_QUERY,  0, 1024, 0);
    send_beat(CMD_ARGMAX, 0, 0, 0);
    send_beat(CMD_ASSIGN, 1023, 1024, VAL_MAX);
    send_beat(CMD_ARGMAX, 5, 9, 0);
    send_beat(CMD_ADD,    0, 1024, VAL_MAX);      // saturates at the top
    send_beat(CMD_QUERY,  1024, 0, 0);            // swapped bounds
    send_beat(CMD_ADD,    0, 512, VAL_MIN);
    send_beat(CMD_ADD,    0, 512, VAL_MIN);       // saturates at the bottom
    send_beat(CMD_QUERY,  0, 512, 0);
    send_beat(CMD_QUERY,  300, 300, 0);           // empty range
    send_beat(CMD_ADD,    7, 7, 55);              // empty write
    send_beat(CMD_ASSIGN, 2047, 1500, -5);        // both past the end
    send_beat(CMD_QUERY,  1000, 2047, 0);
    send_beat(CMD_ASSIGN, 0, 1024, VAL_MIN);
    send_beat(CMD_ARGMAX, 2047, 2047, 0);         // all equal, leftmost wins
    send_beat(CMD_ASSIGN, 400, 401, 9);
    send_beat(CMD_ASSIGN, 700, 701, 9);           // tie: leftmost index
    send_beat(CMD_ARGMAX, 0, 0, 0);
    send_beat(CMD_ADD,    401, 700, 3);
    send_beat(CMD_QUERY,  399, 702, 0);
    send_beat(CMD_QUERY,  0, 1, 0);
    send_beat(CMD_ASSIGN, 0, 1024, 0);

    // random part
    for (int n = 0; n < N_RANDOM; n++) begin
      c = cmd_t'($urandom_range(3));
      l = pick_bound();
      r = pick_bound();
      if ($urandom_range(7) == 0) begin
        l = $urandom_range(1023);
        r = l + 1;
      end
      send_beat(c, l, r, pick_value());
    end
    in_tvalid <= 1'b0;

    // let the checker see the last accepted beat before polling
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
